/* src/nodeset_ancestor_intersection_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef NODESET_ANCESTOR_INTERSECTION_ASSERT_SVH
`define NODESET_ANCESTOR_INTERSECTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NAI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NAI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/nai_pkg.sv */
package nai_pkg;

  localparam int COUNT_W   = 24;
  localparam int SUPPORT_W = 32;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_STREAM = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_STREAM,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic last;
  } nai_head_t;

endpackage

/* src/nodeset_ancestor_intersection.sv */
// Append and clear commands retire one per cycle once they reach the head of the queue while
// no candidate is in progress. A candidate is popped, walks the stored prefix nodes past
// those that precede it without being its ancestor, adds its count to the support if kept,
// and waits for a free result register. The single read port of the prefix store examines
// one stored node per cycle; the next candidate is popped only after the last one's result
// is loaded. Synchronous active-low reset empties the queue and the result register, zeroes
// store length, pointer, support and the overflow flag, and sets the threshold to 1.
module nodeset_ancestor_intersection
  import nai_pkg::*;
#(
  parameter int PREFIX_DEPTH = 1024,
  parameter int CODE_BITS    = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [SUPPORT_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [CODE_BITS-1:0] in_pre_code,
  input  logic [CODE_BITS-1:0] in_post_code,
  input  logic [COUNT_W-1:0]   in_node_count,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kept,
  output logic [CODE_BITS-1:0] out_pre,
  output logic [CODE_BITS-1:0] out_post,
  output logic [COUNT_W-1:0]   out_count,
  output logic [SUPPORT_W-1:0] out_support,
  output logic                 out_frequent,
  output logic                 out_result_last,
  output logic                 out_store_overflow
);

  localparam int AW = $clog2(PREFIX_DEPTH);

  nai_head_t            head;
  logic [CODE_BITS-1:0] head_pre;
  logic [CODE_BITS-1:0] head_post;
  logic [COUNT_W-1:0]   head_count;
  logic                 pop;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*CODE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [2*CODE_BITS-1:0] ram_rdata;

  nai_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_pre    (in_pre_code),
    .in_post   (in_post_code),
    .in_count  (in_node_count),
    .in_last   (in_last),
    .pop       (pop),
    .head      (head),
    .head_pre  (head_pre),
    .head_post (head_post),
    .head_count(head_count)
  );

  nai_ram #(
    .WIDTH(2 * CODE_BITS),
    .DEPTH(PREFIX_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  nai_back #(
    .PREFIX_DEPTH(PREFIX_DEPTH),
    .CODE_BITS   (CODE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .head              (head),
    .head_pre          (head_pre),
    .head_post         (head_post),
    .head_count        (head_count),
    .pop               (pop),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kept          (out_kept),
    .out_pre           (out_pre),
    .out_post          (out_post),
    .out_count         (out_count),
    .out_support       (out_support),
    .out_frequent      (out_frequent),
    .out_result_last   (out_result_last),
    .out_store_overflow(out_store_overflow)
  );

endmodule

/* src/nai_ram.sv */
module nai_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/nai_front.sv */
module nai_front
  import nai_pkg::*;
#(
  parameter int CODE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [CODE_BITS-1:0] in_pre,
  input  logic [CODE_BITS-1:0] in_post,
  input  logic [COUNT_W-1:0]   in_count,
  input  logic                 in_last,
  input  logic                 pop,
  output nai_head_t            head,
  output logic [CODE_BITS-1:0] head_pre,
  output logic [CODE_BITS-1:0] head_post,
  output logic [COUNT_W-1:0]   head_count
);

  logic [1:0]           count_r;
  logic [1:0]           count_nxt;
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  op_t                  op_q   [2];
  logic                 last_q [2];
  logic [CODE_BITS-1:0] pre_q  [2];
  logic [CODE_BITS-1:0] post_q [2];
  logic [COUNT_W-1:0]   cnt_q  [2];
  op_t                  in_op;
  logic                 is_cmd;
  logic                 enq;
  logic                 deq;

  always_comb begin
    in_op  = OP_APPEND;
    is_cmd = 1'b1;
    unique case (in_cmd)
      CMD_APPEND: in_op = OP_APPEND;
      CMD_STREAM: in_op = OP_STREAM;
      CMD_CLEAR:  in_op = OP_CLEAR;
      default:    is_cmd = 1'b0;
    endcase
  end

  assign in_stall = count_r[1];
  assign enq      = in_valid && !in_stall && is_cmd;
  assign deq      = pop && (count_r != 2'd0);

  always_comb begin
    count_nxt = count_r;
    if (enq && !deq) begin
      count_nxt = count_r + 2'd1;
    end else if (deq && !enq) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (enq) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      op_q[wr_ptr_r]   <= in_op;
      last_q[wr_ptr_r] <= in_last;
      pre_q[wr_ptr_r]  <= in_pre;
      post_q[wr_ptr_r] <= in_post;
      cnt_q[wr_ptr_r]  <= in_count;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.op    = op_q[rd_ptr_r];
  assign head.last  = last_q[rd_ptr_r];
  assign head_pre   = pre_q[rd_ptr_r];
  assign head_post  = post_q[rd_ptr_r];
  assign head_count = cnt_q[rd_ptr_r];

endmodule

/* src/nai_back.sv */
module nai_back
  import nai_pkg::*;
#(
  parameter int PREFIX_DEPTH = 1024,
  parameter int CODE_BITS    = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [SUPPORT_W-1:0]            cfg_wr_data,
  input  nai_head_t                       head,
  input  logic [CODE_BITS-1:0]            head_pre,
  input  logic [CODE_BITS-1:0]            head_post,
  input  logic [COUNT_W-1:0]              head_count,
  output logic                            pop,
  output logic                            ram_we,
  output logic [$clog2(PREFIX_DEPTH)-1:0] ram_waddr,
  output logic [2*CODE_BITS-1:0]          ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(PREFIX_DEPTH)-1:0] ram_raddr,
  input  logic [2*CODE_BITS-1:0]          ram_rdata,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kept,
  output logic [CODE_BITS-1:0]            out_pre,
  output logic [CODE_BITS-1:0]            out_post,
  output logic [COUNT_W-1:0]              out_count,
  output logic [SUPPORT_W-1:0]            out_support,
  output logic                            out_frequent,
  output logic                            out_result_last,
  output logic                            out_store_overflow
);

  localparam int AW = $clog2(PREFIX_DEPTH);
  localparam int LW = $clog2(PREFIX_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_LEN = LW'(PREFIX_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SUM,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        ptr_r, ptr_nxt;
  logic [LW-1:0]        ptr_inc;
  logic [SUPPORT_W-1:0] sup_r, sup_nxt;
  logic [SUPPORT_W-1:0] thr_r, thr_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 kept_r, kept_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 frequent_nxt;
  logic                 load_cand;
  logic                 load_out;
  logic                 out_free;
  logic [SUPPORT_W:0]   sum_wide;
  logic [CODE_BITS-1:0] cand_pre_r;
  logic [CODE_BITS-1:0] cand_post_r;
  logic [COUNT_W-1:0]   cand_cnt_r;
  logic                 cand_last_r;
  logic [CODE_BITS-1:0] stored_pre;
  logic [CODE_BITS-1:0] stored_post;

  assign stored_pre  = ram_rdata[2*CODE_BITS-1:CODE_BITS];
  assign stored_post = ram_rdata[CODE_BITS-1:0];
  assign ptr_inc     = ptr_r + 1'b1;
  assign out_free    = !out_valid_r || !out_stall;
  assign sum_wide    = {1'b0, sup_r} + (SUPPORT_W + 1)'(cand_cnt_r);
  assign ram_waddr   = len_r[AW-1:0];
  assign ram_wdata   = {head_pre, head_post};

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    sup_nxt       = sup_r;
    ovf_nxt       = ovf_r;
    kept_nxt      = kept_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    out_valid_nxt = out_valid_r && out_stall;
    frequent_nxt  = 1'b0;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r[AW-1:0];
    load_cand     = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.op)
            OP_APPEND: begin
              if (len_r < DEPTH_LEN) begin
                ram_we  = 1'b1;
                len_nxt = len_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              len_nxt = '0;
              ptr_nxt = '0;
              sup_nxt = '0;
              ovf_nxt = 1'b0;
            end
            OP_STREAM: begin
              load_cand = 1'b1;
              kept_nxt  = 1'b0;
              if (ptr_r < len_r) begin
                ram_re    = 1'b1;
                state_nxt = S_CMP;
              end else begin
                state_nxt = S_SUM;
              end
            end
            default: ;
          endcase
        end
      end
      S_CMP: begin
        if (stored_pre < cand_pre_r) begin
          if (stored_post > cand_post_r) begin
            kept_nxt  = 1'b1;
            state_nxt = S_SUM;
          end else begin
            ptr_nxt = ptr_inc;
            if (ptr_inc < len_r) begin
              ram_re    = 1'b1;
              ram_raddr = ptr_inc[AW-1:0];
            end else begin
              state_nxt = S_SUM;
            end
          end
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (kept_r) begin
          sup_nxt = sum_wide[SUPPORT_W] ? '1 : sum_wide[SUPPORT_W-1:0];
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          frequent_nxt  = cand_last_r && (sup_r >= thr_r);
          if (cand_last_r) begin
            ptr_nxt = '0;
            sup_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      ptr_r       <= '0;
      sup_r       <= '0;
      thr_r       <= SUPPORT_W'(1);
      ovf_r       <= 1'b0;
      kept_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ptr_r       <= ptr_nxt;
      sup_r       <= sup_nxt;
      thr_r       <= thr_nxt;
      ovf_r       <= ovf_nxt;
      kept_r      <= kept_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_cand) begin
        cand_pre_r  <= head_pre;
        cand_post_r <= head_post;
        cand_cnt_r  <= head_count;
        cand_last_r <= head.last;
      end
      if (load_out) begin
        out_kept           <= kept_r;
        out_pre            <= cand_pre_r;
        out_post           <= cand_post_r;
        out_count          <= cand_cnt_r;
        out_support        <= sup_r;
        out_frequent       <= frequent_nxt;
        out_result_last    <= cand_last_r;
        out_store_overflow <= ovf_r;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/nai_checker.sv */
`include "nodeset_ancestor_intersection_assert.svh"

module nai_checker
  import nai_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_kept,
  input logic [COUNT_W-1:0]   out_count,
  input logic [SUPPORT_W-1:0] out_support,
  input logic                 out_frequent,
  input logic                 out_result_last
);

  `NAI_ASSERT_NEXT(a_valid_held, out_valid && out_stall, out_valid, "result dropped while stalled")
  `NAI_ASSERT_NEXT(a_support_held, out_valid && out_stall, $stable(out_support), "support changed while stalled")
  `NAI_ASSERT_NOW(a_frequent_last, out_valid && !out_result_last, !out_frequent, "frequent set before the last node")
  `NAI_ASSERT_NOW(a_kept_support, out_valid && out_kept && (out_count != '0), out_support != '0, "kept node left support at zero")

endmodule

bind nodeset_ancestor_intersection nai_checker u_nai_checker (.*);

/* test/tb_top.sv */
module tb_top;
  import nai_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CODE_W = 24;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [CODE_W-1:0] CODE_MAX = 24'hFFFFFF;
  localparam logic [SUPPORT_W-1:0] SUPPORT_MAX = 32'hFFFFFFFF;
  localparam int HOLD_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct {
    logic                 kept;
    logic [CODE_W-1:0]    pre;
    logic [CODE_W-1:0]    post;
    logic [COUNT_W-1:0]   count;
    logic [SUPPORT_W-1:0] support;
    logic                 frequent;
    logic                 last;
    logic                 overflow;
  } node_result_t;

  class ancestor_scoreboard;
    logic [CODE_W-1:0] pre_mem [DEPTH];
    logic [CODE_W-1:0] post_mem [DEPTH];
    int unsigned stored_len = 0;
    int unsigned walk_ptr = 0;
    logic [SUPPORT_W-1:0] support_sum = '0;
    logic overflow = 1'b0;
    logic [SUPPORT_W-1:0] threshold = 1;
    node_result_t expected_q[$];
    int errors = 0;

    function void set_threshold(logic [SUPPORT_W-1:0] value);
      threshold = value;
    endfunction

    function void note_transfer(logic [1:0] cmd, logic [CODE_W-1:0] pre,
                                logic [CODE_W-1:0] post, logic [COUNT_W-1:0] cnt,
                                logic last);
      node_result_t r;
      logic [SUPPORT_W:0] sum;
      r.kept = 1'b0;
      case (cmd)
        CMD_APPEND: begin
          if (stored_len < DEPTH) begin
            pre_mem[stored_len] = pre;
            post_mem[stored_len] = post;
            stored_len++;
          end else begin
            overflow = 1'b1;
          end
        end
        CMD_CLEAR: begin
          stored_len = 0;
          walk_ptr = 0;
          support_sum = '0;
          overflow = 1'b0;
        end
        CMD_STREAM: begin
          while (walk_ptr < stored_len) begin
            if (pre_mem[walk_ptr] < pre) begin
              if (post_mem[walk_ptr] > post) begin
                r.kept = 1'b1;
                break;
              end
              walk_ptr++;
            end else begin
              break;
            end
          end
          if (r.kept) begin
            sum = {1'b0, support_sum} + cnt;
            support_sum = sum[SUPPORT_W] ? SUPPORT_MAX : sum[SUPPORT_W-1:0];
          end
          r.pre = pre;
          r.post = post;
          r.count = cnt;
          r.support = support_sum;
          r.frequent = last && (support_sum >= threshold);
          r.last = last;
          r.overflow = overflow;
          expected_q.push_back(r);
          if (last) begin
            walk_ptr = 0;
            support_sum = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(node_result_t got);
      node_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected result");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kept", want.kept, got.kept);
      compare_field("out_pre", want.pre, got.pre);
      compare_field("out_post", want.post, got.post);
      compare_field("out_count", want.count, got.count);
      compare_field("support", want.support, got.support);
      compare_field("frequent", want.frequent, got.frequent);
      compare_field("result_last", want.last, got.last);
      compare_field("store_overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [SUPPORT_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_cmd;
  logic [CODE_W-1:0] in_pre_code;
  logic [CODE_W-1:0] in_post_code;
  logic [COUNT_W-1:0] in_node_count;
  logic in_last;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kept;
  logic [CODE_W-1:0] out_pre;
  logic [CODE_W-1:0] out_post;
  logic [COUNT_W-1:0] out_count;
  logic [SUPPORT_W-1:0] out_support;
  logic out_frequent;
  logic out_result_last;
  logic out_store_overflow;

  ancestor_scoreboard sb;
  node_result_t seen;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int unsigned stall_cycle = 0;
  stall_mode_t stall_mode = STALL_NONE;

  nodeset_ancestor_intersection #(
    .PREFIX_DEPTH(DEPTH),
    .CODE_BITS(CODE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_pre_code(in_pre_code),
    .in_post_code(in_post_code),
    .in_node_count(in_node_count),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kept(out_kept),
    .out_pre(out_pre),
    .out_post(out_post),
    .out_count(out_count),
    .out_support(out_support),
    .out_frequent(out_frequent),
    .out_result_last(out_result_last),
    .out_store_overflow(out_store_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle[7:0] == 8'd0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_cycle % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kept = out_kept;
      seen.pre = out_pre;
      seen.post = out_post;
      seen.count = out_count;
      seen.support = out_support;
      seen.frequent = out_frequent;
      seen.last = out_result_last;
      seen.overflow = out_store_overflow;
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] rand_code();
    return $urandom_range(0, CODE_MAX);
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    return $urandom_range(0, CODE_MAX);
  endfunction

  task automatic send_node(input logic [1:0] cmd, input logic [CODE_W-1:0] pre,
                           input logic [CODE_W-1:0] post, input logic [COUNT_W-1:0] cnt,
                           input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_pre_code <= pre;
    in_post_code <= post;
    in_node_count <= cnt;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(cmd, pre, post, cnt, last);
    if (cmd != CMD_NOP) begin
      items_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SUPPORT_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_threshold(value);
  endtask

  task automatic run_random_set(input bit force_clear);
    int n_pref;
    int n_cand;
    int step_max;
    logic [CODE_W-1:0] base;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] post_span;
    bit open_stream;
    if (force_clear || $urandom_range(0, 7) == 0) begin
      send_node(CMD_CLEAR, rand_code(), rand_code(), rand_count(), $urandom_range(0, 1));
    end
    n_pref = $urandom_range(0, 10);
    n_cand = $urandom_range(1, 10);
    base = $urandom_range(0, 24'hFF0000);
    step_max = $urandom_range(0, 1) ? 8 : 4096;
    post_span = $urandom_range(0, 1) ? 24'd63 : CODE_MAX;
    open_stream = ($urandom_range(0, 15) == 0);
    code = base;
    for (int p = 0; p < n_pref; p++) begin
      send_node(CMD_APPEND, code, $urandom_range(0, post_span), rand_count(),
                $urandom_range(0, 1));
      code += $urandom_range(0, step_max);
    end
    code = base;
    for (int c = 0; c < n_cand; c++) begin
      case ($urandom_range(0, 19))
        0: send_node(CMD_NOP, rand_code(), rand_code(), rand_count(), $urandom_range(0, 1));
        1: send_node(CMD_APPEND, code, rand_code(), rand_count(), 1'b0);
        2: send_node(CMD_STREAM, rand_code(), rand_code(), rand_count(), 1'b0);
        default: ;
      endcase
      code += $urandom_range(0, step_max);
      send_node(CMD_STREAM, code, $urandom_range(0, post_span),
                $urandom_range(0, 1) ? rand_count() : $urandom_range(0, 15),
                (c == n_cand - 1) && !open_stream);
    end
  endtask

  initial begin
    logic [CODE_W-1:0] code;
    logic [SUPPORT_W-1:0] thr;
    int set_index;
    sb = new;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_cmd <= CMD_NOP;
    in_pre_code <= '0;
    in_post_code <= '0;
    in_node_count <= '0;
    in_last <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_node(CMD_CLEAR, 24'd0, 24'd0, 24'd0, 1'b0);
    send_node(CMD_APPEND, 24'd10, 24'd100, CODE_MAX, 1'b1);
    send_node(CMD_APPEND, 24'd20, 24'd30, 24'd0, 1'b0);
    send_node(CMD_APPEND, 24'd40, 24'd90, 24'd0, 1'b0);
    send_node(CMD_STREAM, 24'd5, 24'd200, CODE_MAX, 1'b0);
    send_node(CMD_STREAM, 24'd15, 24'd50, 24'd0, 1'b0);
    send_node(CMD_STREAM, 24'd25, 24'd20, CODE_MAX, 1'b0);
    send_node(CMD_STREAM, 24'd50, 24'd95, 24'd1, 1'b0);
    send_node(CMD_STREAM, 24'd60, 24'd150, 24'd7, 1'b0);
    send_node(CMD_NOP, CODE_MAX, CODE_MAX, CODE_MAX, 1'b1);
    send_node(CMD_STREAM, 24'd70, 24'd0, 24'd3, 1'b1);
    send_node(CMD_STREAM, CODE_MAX, 24'd0, CODE_MAX, 1'b1);
    send_node(CMD_STREAM, 24'd0, CODE_MAX, 24'd5, 1'b1);
    send_node(CMD_STREAM, 24'd11, 24'd5, 24'd9, 1'b0);
    send_node(CMD_APPEND, 24'd200, 24'd300, 24'd0, 1'b0);
    send_node(CMD_STREAM, 24'd250, 24'd250, 24'd2, 1'b1);
    send_node(CMD_CLEAR, CODE_MAX, CODE_MAX, CODE_MAX, 1'b1);
    send_node(CMD_STREAM, 24'd1, 24'd0, 24'd4, 1'b1);
    send_node(CMD_APPEND, CODE_MAX - 24'd1, CODE_MAX, 24'd0, 1'b0);
    send_node(CMD_APPEND, CODE_MAX, 24'd0, 24'd0, 1'b0);
    send_node(CMD_STREAM, CODE_MAX, 24'd0, CODE_MAX, 1'b1);

    send_node(CMD_CLEAR, 24'd0, 24'd0, 24'd0, 1'b0);
    for (int i = 0; i < DEPTH + 4; i++) begin
      send_node(CMD_APPEND, 24'(i * 4), $urandom_range(0, 255), rand_count(),
                $urandom_range(0, 1));
    end
    code = 24'd2;
    for (int c = 0; c < 12; c++) begin
      send_node(CMD_STREAM, code, $urandom_range(0, 300), rand_count(), c == 11);
      code += $urandom_range(200, 400);
    end
    send_node(CMD_APPEND, CODE_MAX, CODE_MAX, 24'd0, 1'b0);

    write_threshold(SUPPORT_MAX);
    send_node(CMD_CLEAR, 24'd0, 24'd0, 24'd0, 1'b0);
    send_node(CMD_APPEND, 24'd0, CODE_MAX, 24'd0, 1'b0);
    for (int c = 1; c <= 300; c++) begin
      send_node(CMD_STREAM, 24'(c), 24'd0, CODE_MAX - 24'($urandom_range(0, 3)), c == 300);
    end

    items_sent = 0;
    set_index = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (set_index == 0 || $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: thr = 32'd1;
          1: thr = SUPPORT_MAX;
          2: thr = $urandom_range(1, 64);
          3: thr = $urandom_range(1, 32'h0FFFFFFF);
          default: thr = ($urandom == 0) ? 32'd1 : $urandom;
        endcase
        write_threshold(thr);
      end
      run_random_set(set_index == 0);
      set_index++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/nai_pkg.sv
src/nai_ram.sv
src/nai_front.sv
src/nai_back.sv
src/nodeset_ancestor_intersection.sv
src/nai_checker.sv
test/tb_top.sv
